>>> hw/rtl/drip_rate_averager_alarm_defines.svh
// assertion macros for the drip rate averager
`ifndef DRIP_RATE_AVERAGER_ALARM_DEFINES_SVH
`define DRIP_RATE_AVERAGER_ALARM_DEFINES_SVH

// condition holds at every edge out of reset
`define DRA_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("dra assertion failed");

// antecedent at one edge implies consequent at the next
`define DRA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dra assertion failed");

// antecedent implies consequent at the same edge
`define DRA_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dra assertion failed");

`endif

>>> hw/rtl/dra_pkg.sv
package dra_pkg;

   // history
   localparam int HistDepth = 8;
   localparam int IdxW      = $clog2(HistDepth);
   localparam int RateW     = 16;
   localparam int SumW      = RateW + $clog2(HistDepth);

   // rate division: 60 s * 32768 Hz over the drop interval
   localparam int NumW                 = 21;
   localparam logic [NumW-1:0] RateNum = NumW'(1966080);
   localparam int BitW                 = $clog2(NumW);
   localparam int DivW                 = 32;

   localparam logic [RateW-1:0] RefillDelta = RateW'(20);
   localparam logic [15:0]      TimerGate   = 16'd10;
   localparam logic [15:0]      TimerMax    = 16'd60000;
   localparam logic [7:0]       MissLimit   = 8'd5;
   localparam logic [7:0]       MissMax     = 8'd255;

   // port packing
   localparam int ReqDataW = 40;
   localparam int RspDataW = 24;
   localparam int CfgW     = 8;

   typedef enum logic { ActRate = 1'b0, ActTick = 1'b1 } action_type;

   typedef enum logic [1:0] {
      ModeNone     = 2'd0,
      ModeMeasured = 2'd1,
      ModeTimedOut = 2'd2,
      ModeOther    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      AlarmNone = 2'd0,
      AlarmFast = 2'd1,
      AlarmSlow = 2'd2
   } alarm_type;

   typedef enum logic { RegUpper = 1'b0, RegLower = 1'b1 } reg_index_type;

endpackage

>>> hw/rtl/drip_rate_averager_alarm.sv
// Drip rate averager with rate alarm.
// req channel: one transfer per event. tuser = action (0 rate request, 1 half-second
// tick); tdata carries the drop interval and the rate mode.
// rsp channel: exactly one transfer per req transfer (tick or rate request), average rate and alarm code.
// csr channel: writes the upper (index 0) and lower (index 1) alarm thresholds; always
// ready, to be written only while the block is idle.
// Sequence: an accepted tick runs the history sum steps and then the check step. A rate
// request with a measured, nonzero interval runs the radix-2 restoring divider, the
// history update step, the history sum steps and the check step. Other rate requests
// skip the divider and start at the history update step.
// req_tready returns together with rsp_tvalid, when the result is registered.
// One item is worked on at a time; req_tready is high only while the sequencer idles.
// A finished result sits in the output register, so the next item may be accepted
// while rsp waits; if rsp_tready stays low the sequencer then holds in its check step.
// Synchronous reset clears the history, alarm timer, miss count and output valid and
// loads the thresholds with 255 and 0.
`include "drip_rate_averager_alarm_defines.svh"

module drip_rate_averager_alarm (
   input  logic                         clock,
   input  logic                         reset,
   // req_tdata: interval_overflows[15:0], interval_count[31:16], rate_mode[33:32]
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [dra_pkg::ReqDataW-1:0] req_tdata,
   // req_tuser: action[0]
   input  logic                         req_tuser,
   // rsp_tdata: average_rate[15:0], alarm[17:16]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [dra_pkg::RspDataW-1:0] rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [dra_pkg::CfgW-1:0]     csr_data
);
   import dra_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_UPD,
      S_SUM,
      S_CHK
   } state_type;

   state_type              state_ff;
   logic [CfgW-1:0]        upper_ff;
   logic [CfgW-1:0]        lower_ff;
   logic [RateW-1:0]       hist_ff [HistDepth];
   logic [15:0]            timer_ff;
   logic [7:0]             miss_ff;
   logic                   check_ff;
   logic [DivW-1:0]        divisor_ff;
   logic [DivW:0]          rem_ff;
   logic [NumW-1:0]        quot_ff;
   logic [BitW-1:0]        bit_ff;
   logic [RateW-1:0]       rate_ff;
   logic [SumW-1:0]        sum_ff;
   logic [IdxW-1:0]        idx_ff;
   logic                   rsp_valid_ff;
   logic [RateW-1:0]       rsp_avg_ff;
   alarm_type              rsp_alarm_ff;

   logic [15:0]            req_ovf;
   logic [15:0]            req_cnt;
   mode_type               req_mode;
   logic [DivW-1:0]        interval_in;
   logic [DivW:0]          trial_in;
   logic                   ge_in;
   logic [NumW-1:0]        quot_in;
   logic [RateW-1:0]       rate_sat_in;
   logic [RateW-1:0]       gap_in;
   logic                   fill_in;
   logic [RateW-1:0]       avg_in;
   logic                   fast_in;
   logic                   slow_in;
   logic [7:0]             miss_in;
   logic                   out_free;
   logic [RateW-1:0]       hist_gap_in;

   assign req_ovf     = req_tdata[15:0];
   assign req_cnt     = req_tdata[31:16];
   assign req_mode    = mode_type'(req_tdata[33:32]);
   assign interval_in = {1'b0, req_ovf, 15'd0} + {16'd0, req_cnt};

   // one restoring division step per cycle, numerator bits fed msb first
   assign trial_in    = {rem_ff[DivW-1:0], RateNum[bit_ff]};
   assign ge_in       = trial_in >= {1'b0, divisor_ff};
   assign quot_in     = {quot_ff[NumW-2:0], ge_in};
   assign rate_sat_in = (quot_in > NumW'({RateW{1'b1}})) ? {RateW{1'b1}}
                                                         : quot_in[RateW-1:0];

   // refill when the history looks empty or the new rate jumps away from the newest one
   assign gap_in  = (hist_ff[0] >= rate_ff) ? hist_ff[0] - rate_ff : rate_ff - hist_ff[0];
   assign fill_in = ((hist_ff[0] == '0) && (hist_ff[HistDepth-1] == '0)) ||
                    (gap_in > RefillDelta);

   assign avg_in  = RateW'(sum_ff / SumW'(HistDepth));
   assign fast_in = avg_in >= {8'd0, upper_ff};
   assign slow_in = avg_in <= {8'd0, lower_ff};
   assign miss_in = (miss_ff < MissMax) ? miss_ff + 8'd1 : miss_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_alarm_ff, rsp_avg_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         upper_ff     <= 8'd255;
         lower_ff     <= 8'd0;
         timer_ff     <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < HistDepth; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               RegUpper: upper_ff <= csr_data;
               RegLower: lower_ff <= csr_data;
               default:  ;
            endcase
         end

         if ((state_ff == S_CHK) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  if (action_type'(req_tuser) == ActTick) begin
                     if (timer_ff < TimerMax) begin
                        timer_ff <= timer_ff + 16'd1;
                     end
                     check_ff <= 1'b0;
                     sum_ff   <= '0;
                     idx_ff   <= '0;
                     state_ff <= S_SUM;
                  end else begin
                     check_ff   <= (req_mode != ModeNone);
                     divisor_ff <= interval_in;
                     rem_ff     <= '0;
                     quot_ff    <= '0;
                     bit_ff     <= BitW'(NumW - 1);
                     rate_ff    <= '0;
                     if ((req_mode == ModeMeasured) && (interval_in != '0)) begin
                        state_ff <= S_DIV;
                     end else begin
                        state_ff <= S_UPD;
                     end
                  end
               end
            end
            S_DIV: begin
               rem_ff  <= ge_in ? trial_in - {1'b0, divisor_ff} : trial_in;
               quot_ff <= quot_in;
               bit_ff  <= bit_ff - BitW'(1);
               if (bit_ff == '0) begin
                  rate_ff  <= rate_sat_in;
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               if (fill_in) begin
                  for (int k = 0; k < HistDepth; k++) begin
                     hist_ff[k] <= rate_ff;
                  end
               end else begin
                  for (int k = 1; k < HistDepth; k++) begin
                     hist_ff[k] <= hist_ff[k-1];
                  end
                  hist_ff[0] <= rate_ff;
               end
               sum_ff   <= '0;
               idx_ff   <= '0;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               sum_ff <= sum_ff + SumW'(hist_ff[idx_ff]);
               idx_ff <= idx_ff + IdxW'(1);
               if (idx_ff == IdxW'(HistDepth - 1)) begin
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (out_free) begin
                  rsp_avg_ff   <= avg_in;
                  rsp_alarm_ff <= AlarmNone;
                  if (check_ff && (timer_ff >= TimerGate)) begin
                     if (fast_in || slow_in) begin
                        miss_ff  <= miss_in;
                        timer_ff <= '0;
                        if (miss_in >= MissLimit) begin
                           rsp_alarm_ff <= fast_in ? AlarmFast : AlarmSlow;
                        end
                     end else begin
                        miss_ff <= '0;
                     end
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign hist_gap_in = (hist_ff[0] >= hist_ff[1]) ? hist_ff[0] - hist_ff[1]
                                                  : hist_ff[1] - hist_ff[0];

   // an alarm shown on the output is backed by enough consecutive misses
   `DRA_ASSERT_SAME(a_alarm_needs_misses, rsp_valid_ff && (rsp_alarm_ff != AlarmNone), miss_ff >= MissLimit)
   // an accepted item always takes the sequencer out of idle
   `DRA_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   // after a history update the two newest entries are within the refill window
   `DRA_ASSERT_NEXT(a_history_settled, state_ff == S_UPD, hist_gap_in <= RefillDelta)
   // the timer never runs past its ceiling
   `DRA_ASSERT_ALWAYS(a_timer_capped, timer_ff <= TimerMax)

endmodule
